### design/mdas_pkg.sv
// ----------------------------------------------------------------------------
// mdas_pkg: shared types and constants of the median depth autofocus smoother
// Holds field widths, register indexes, controller states, the command and
// status bundles and the function that builds the per-millisecond decay table.
// ----------------------------------------------------------------------------
package mdas_pkg;

  // Field geometry.
  localparam int WINDOW_SAMPLES = 9;
  localparam int DEPTH_BITS     = 24;
  localparam int DIST_FRAC_BITS = 12;
  localparam int DIST_W         = 2 * DIST_FRAC_BITS;
  localparam int MS_W           = 16;
  localparam int COUNT_W        = 4;
  localparam int MIN_KEPT       = 3;
  localparam int IDX_W          = $clog2(WINDOW_SAMPLES);
  localparam int CNT_W          = $clog2((WINDOW_SAMPLES > DIST_W) ? WINDOW_SAMPLES : DIST_W);

  // Default cap on the elapsed time, in milliseconds.
  localparam int ELAPSED_CAP_MS = 250;

  // Q1.30 arithmetic of the smoothing factor.
  localparam int ALPHA_W = 31;
  localparam logic [63:0] Q30_ONE      = 64'd1 << 30;
  localparam logic [63:0] Q30_HALF     = 64'd1 << 29;
  localparam logic [63:0] DECAY_PER_MS = 64'd1070678369;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIST_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR  = 2'd0,
    CFG_FAR   = 2'd1,
    CFG_LIMIT = 2'd2
  } cfg_reg_t;

  localparam logic [DIST_W-1:0]     NEAR_RESET  = 24'd4096;
  localparam logic [DIST_W-1:0]     FAR_RESET   = 24'd16773120;
  localparam logic [DEPTH_BITS-1:0] LIMIT_RESET = 24'd16775538;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANK,
    ST_MUL,
    ST_DEN,
    ST_DIV,
    ST_SEL,
    ST_STEP,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             rank_en;
    logic [IDX_W-1:0] rank_idx;
    logic             mul_en;
    logic             den_en;
    logic             div_en;
    logic             sel_en;
    logic             step_en;
    logic             commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_restart;
    logic do_median;
    logic out_busy;
  } status_t;

  // Keep factor after ms rounded decay steps, Q1.30.
  function automatic logic [ALPHA_W-1:0] keep_factor(input int unsigned ms);
    logic [63:0] k;
    k = Q30_ONE;
    for (int unsigned i = 0; i < ms; i++) begin
      k = (k * DECAY_PER_MS + Q30_HALF) >> 30;
    end
    return k[ALPHA_W-1:0];
  endfunction

endpackage

### design/mdas_if.sv
// ----------------------------------------------------------------------------
// mdas_if: channel interfaces of the median depth autofocus smoother
// One interface for the incoming window transactions and one for results.
// ----------------------------------------------------------------------------
interface mdas_in_if;
  import mdas_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [DEPTH_BITS-1:0] depth_0;
  logic [DEPTH_BITS-1:0] depth_1;
  logic [DEPTH_BITS-1:0] depth_2;
  logic [DEPTH_BITS-1:0] depth_3;
  logic [DEPTH_BITS-1:0] depth_4;
  logic [DEPTH_BITS-1:0] depth_5;
  logic [DEPTH_BITS-1:0] depth_6;
  logic [DEPTH_BITS-1:0] depth_7;
  logic [DEPTH_BITS-1:0] depth_8;
  logic [DIST_W-1:0]     hint_distance;
  logic [MS_W-1:0]       elapsed_ms;
  logic                  restart;

  modport source (
    output valid, depth_0, depth_1, depth_2, depth_3, depth_4, depth_5, depth_6,
           depth_7, depth_8, hint_distance, elapsed_ms, restart,
    input  ready
  );
  modport sink (
    input  valid, depth_0, depth_1, depth_2, depth_3, depth_4, depth_5, depth_6,
           depth_7, depth_8, hint_distance, elapsed_ms, restart,
    output ready
  );
endinterface

interface mdas_out_if;
  import mdas_pkg::*;

  logic               valid;
  logic               ready;
  logic [DIST_W-1:0]  focus_distance;
  logic [DIST_W-1:0]  visible_distance;
  logic               used_visible;
  logic [COUNT_W-1:0] valid_count;
  logic               focus_valid;

  modport source (
    output valid, focus_distance, visible_distance, used_visible, valid_count,
           focus_valid,
    input  ready
  );
  modport sink (
    input  valid, focus_distance, visible_distance, used_visible, valid_count,
           focus_valid,
    output ready
  );
endinterface

### design/mdas_ctrl.sv
// ----------------------------------------------------------------------------
// mdas_ctrl: sequencing state machine
// Steps one transaction through ranking, linearization, division, target
// selection, smoothing and result hand-off.
// ----------------------------------------------------------------------------
module mdas_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  mdas_pkg::status_t status,
  output logic              ready,
  output mdas_pkg::cmd_t    cmd
);
  import mdas_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Step counter for the ranking and division loops; restarts on each state change.
  always_ff @(posedge clk) begin
    if (rst || state != state_next) begin
      cnt <= '0;
    end else if (state == ST_RANK || state == ST_DIV) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_RANK;
      end
      ST_RANK: begin
        if (cnt == CNT_W'(WINDOW_SAMPLES - 1)) begin
          if (status.is_restart)     state_next = ST_DONE;
          else if (status.do_median) state_next = ST_MUL;
          else                       state_next = ST_SEL;
        end
      end
      ST_MUL:  state_next = ST_DEN;
      ST_DEN:  state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == CNT_W'(DIST_W - 1)) state_next = ST_SEL;
      end
      ST_SEL:  state_next = ST_STEP;
      ST_STEP: state_next = ST_DONE;
      ST_DONE: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd          = '0;
    cmd.rank_idx = cnt[IDX_W-1:0];
    ready        = 1'b0;
    case (state)
      ST_IDLE: begin
        ready    = 1'b1;
        cmd.load = accept;
      end
      ST_RANK: cmd.rank_en = 1'b1;
      ST_MUL:  cmd.mul_en  = 1'b1;
      ST_DEN:  cmd.den_en  = 1'b1;
      ST_DIV:  cmd.div_en  = 1'b1;
      ST_SEL:  cmd.sel_en  = 1'b1;
      ST_STEP: cmd.step_en = 1'b1;
      ST_DONE: cmd.commit  = !status.out_busy;
      default: ready       = 1'b0;
    endcase
  end

endmodule

### design/mdas_dp.sv
// ----------------------------------------------------------------------------
// mdas_dp: datapath of the median depth autofocus smoother
// Configuration registers, sample filter and rank-based median pick, two
// multipliers, a radix-2 divider, the decay table and the smoothing step.
// ----------------------------------------------------------------------------
module mdas_dp #(
  parameter int ELAPSED_CAP_MS = mdas_pkg::ELAPSED_CAP_MS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mdas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mdas_pkg::CFG_DATA_W-1:0] cfg_data,
  input  mdas_pkg::cmd_t                  cmd,
  output mdas_pkg::status_t               status,
  mdas_in_if.sink                         req,
  mdas_out_if.source                      rsp
);
  import mdas_pkg::*;

  localparam int T_W = $clog2(ELAPSED_CAP_MS + 1);

  // Configuration registers.
  logic [DIST_W-1:0]     near_plane;
  logic [DIST_W-1:0]     far_plane;
  logic [DEPTH_BITS-1:0] valid_depth_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_plane        <= NEAR_RESET;
      far_plane         <= FAR_RESET;
      valid_depth_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_NEAR:  near_plane        <= cfg_data[DIST_W-1:0];
        CFG_FAR:   far_plane         <= cfg_data[DIST_W-1:0];
        CFG_LIMIT: valid_depth_limit <= cfg_data[DEPTH_BITS-1:0];
        default:   near_plane        <= near_plane;
      endcase
    end
  end

  // Incoming window gathered into an array.
  logic [DEPTH_BITS-1:0] win_in [WINDOW_SAMPLES];
  assign win_in[0] = req.depth_0;
  assign win_in[1] = req.depth_1;
  assign win_in[2] = req.depth_2;
  assign win_in[3] = req.depth_3;
  assign win_in[4] = req.depth_4;
  assign win_in[5] = req.depth_5;
  assign win_in[6] = req.depth_6;
  assign win_in[7] = req.depth_7;
  assign win_in[8] = req.depth_8;

  // Transaction registers.
  logic [DEPTH_BITS-1:0]     win [WINDOW_SAMPLES];
  logic [WINDOW_SAMPLES-1:0] kept;
  logic [COUNT_W-1:0]        count;
  logic [DIST_W-1:0]         hint;
  logic [T_W-1:0]            t_ms;
  logic                      restart_q;

  logic [WINDOW_SAMPLES-1:0] kept_in;
  logic [COUNT_W-1:0]        count_in;

  // Keep samples strictly between zero and the limit.
  always_comb begin
    count_in = '0;
    for (int i = 0; i < WINDOW_SAMPLES; i++) begin
      kept_in[i] = (win_in[i] != '0) && (win_in[i] < valid_depth_limit);
      count_in   = count_in + COUNT_W'(kept_in[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      win       <= win_in;
      kept      <= kept_in;
      count     <= count_in;
      hint      <= req.hint_distance;
      restart_q <= req.restart;
      t_ms      <= (req.elapsed_ms > MS_W'(ELAPSED_CAP_MS)) ? T_W'(ELAPSED_CAP_MS)
                                                            : req.elapsed_ms[T_W-1:0];
    end
  end

  // Rank of the sample under test; ties break by position.
  logic [DEPTH_BITS-1:0] cand;
  logic [COUNT_W-1:0]    rank;
  logic [DEPTH_BITS-1:0] median;

  always_comb begin
    cand = win[cmd.rank_idx];
    rank = '0;
    for (int j = 0; j < WINDOW_SAMPLES; j++) begin
      if (kept[j] && ((win[j] < cand) ||
                      ((win[j] == cand) && (IDX_W'(j) < cmd.rank_idx)))) begin
        rank = rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rank_en && kept[cmd.rank_idx] && rank == (count >> 1)) begin
      median <= cand;
    end
  end

  // Linearization products.
  logic [DEPTH_BITS+DIST_W-1:0] scaled;
  logic [2*DIST_W-1:0]          nf_prod;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      scaled  <= median * (far_plane - near_plane);
      nf_prod <= near_plane * far_plane;
    end
  end

  // Restoring divider: one quotient bit per cycle.
  logic [DIST_W-1:0] den;
  logic [DIST_W-1:0] rem;
  logic [DIST_W-1:0] quo;
  logic              have;
  logic [DIST_W:0]   trial;
  logic              fits;

  assign trial = {rem, quo[DIST_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      have <= 1'b0;
    end else if (cmd.den_en) begin
      den  <= far_plane - scaled[DEPTH_BITS +: DIST_W];
      rem  <= nf_prod[DIST_W +: DIST_W];
      quo  <= nf_prod[DIST_W-1:0];
      have <= 1'b1;
    end else if (cmd.div_en) begin
      rem <= fits ? DIST_W'(trial - {1'b0, den}) : trial[DIST_W-1:0];
      quo <= {quo[DIST_W-2:0], fits};
    end
  end

  // Decay table with registered read.
  logic [ALPHA_W-1:0] keep_rom [ELAPSED_CAP_MS + 1];
  logic [ALPHA_W-1:0] alpha;

  for (genvar g = 0; g <= ELAPSED_CAP_MS; g++) begin : g_rom
    assign keep_rom[g] = keep_factor(g);
  end

  always_ff @(posedge clk) begin
    alpha <= ALPHA_W'(Q30_ONE) - keep_rom[t_ms];
  end

  // Held focus.
  logic [DIST_W-1:0] smoothed;
  logic              held;

  // Target selection against the hint.
  logic [DIST_W-1:0]   vis;
  logic [DIST_W-1:0]   vis_q;
  logic [DIST_W-1:0]   diff;
  logic                used_c;
  logic                used_q;
  logic [DIST_W-1:0]   target_c;
  logic [DIST_W-1:0]   target;
  logic [DIST_W-1:0]   mag;
  logic                up;

  always_comb begin
    vis      = have ? quo : '0;
    diff     = (vis > hint) ? vis - hint : hint - vis;
    used_c   = have && (vis > near_plane) && (vis < far_plane) &&
               ({diff, 2'b00} < {2'b00, hint});
    target_c = used_c ? vis : hint;
  end

  always_ff @(posedge clk) begin
    if (cmd.sel_en) begin
      vis_q  <= vis;
      used_q <= used_c;
      target <= target_c;
      up     <= target_c >= smoothed;
      mag    <= (target_c >= smoothed) ? target_c - smoothed : smoothed - target_c;
    end
  end

  // Smoothing product.
  logic [DIST_W+ALPHA_W-1:0] step_prod;
  logic [DIST_W+ALPHA_W:0]   step_round;
  logic [DIST_W-1:0]         step;

  always_ff @(posedge clk) begin
    if (cmd.step_en) begin
      step_prod <= mag * alpha;
    end
  end

  assign step_round = {1'b0, step_prod} + (DIST_W+ALPHA_W+1)'(Q30_HALF);
  assign step       = step_round[30 +: DIST_W];

  // State update and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= 1'b0;
      smoothed <= '0;
    end else if (cmd.commit) begin
      if (restart_q) begin
        held <= 1'b0;
      end else begin
        held <= 1'b1;
        if (!held)   smoothed <= target;
        else if (up) smoothed <= smoothed + step;
        else         smoothed <= smoothed - step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (restart_q) begin
        rsp.focus_distance   <= smoothed;
        rsp.visible_distance <= '0;
        rsp.used_visible     <= 1'b0;
        rsp.valid_count      <= '0;
        rsp.focus_valid      <= 1'b0;
      end else begin
        rsp.focus_distance   <= !held ? target : (up ? smoothed + step : smoothed - step);
        rsp.visible_distance <= vis_q;
        rsp.used_visible     <= used_q;
        rsp.valid_count      <= count;
        rsp.focus_valid      <= 1'b1;
      end
    end
  end

  // Status to the controller.
  assign status.is_restart = restart_q;
  assign status.do_median  = (count >= COUNT_W'(MIN_KEPT)) && (far_plane > near_plane);
  assign status.out_busy   = rsp.valid && !rsp.ready;

  // A committed result is presented in the next cycle.
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp.valid) else $error("result not presented after commit");

  // A completed non-restart transaction leaves the focus established.
  a_held_set: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && !restart_q |=> held) else $error("held focus flag not set");

  // The median can only replace the hint with enough kept samples.
  a_used_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.used_visible |-> rsp.valid_count >= COUNT_W'(MIN_KEPT))
    else $error("measured distance used with too few samples");

  // A restart result carries no measurement.
  a_restart_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.focus_valid |-> rsp.valid_count == '0 && !rsp.used_visible)
    else $error("restart result carries measurement fields");

endmodule

### design/median_depth_autofocus_smoother.sv
// ----------------------------------------------------------------------------
// median_depth_autofocus_smoother: median depth probe with focus smoothing
// Picks the median of the valid window depths, linearizes it, checks it
// against the hinted distance and eases the held focus toward the target.
//
//   Channel  Direction  Handshake          Contents
//   req      in         valid/ready        nine raw depths, hint, elapsed ms, restart
//   rsp      out        valid/ready        focus, visible distance, flags, count
//   cfg      in         cfg_we only        near, far, valid depth limit
//
// A transaction is ranked (9 steps); with a median it is then linearized in the
// multiply, denominator and radix-2 divider (24 steps) states. It is selected,
// smoothed and handed off, but a restart goes from ranking to hand-off. One
// transaction is in flight at a time; the next is accepted once the result is registered.
// Synchronous reset clears the held focus and restores the register defaults.
// A stalled result holds the machine in its final state until it is taken.
// ----------------------------------------------------------------------------
module median_depth_autofocus_smoother #(
  parameter int ELAPSED_CAP_MS = mdas_pkg::ELAPSED_CAP_MS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mdas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mdas_pkg::CFG_DATA_W-1:0] cfg_data,
  mdas_in_if.sink                         req,
  mdas_out_if.source                      rsp
);
  import mdas_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    ready;

  assign req.ready = ready;

  mdas_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (req.valid && ready),
    .status (status),
    .ready  (ready),
    .cmd    (cmd)
  );

  mdas_dp #(
    .ELAPSED_CAP_MS (ELAPSED_CAP_MS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .req       (req),
    .rsp       (rsp)
  );

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the median depth autofocus smoother
// Drives window transactions with random gaps and back-pressure, predicts
// every result from an independent model of median, linearization and
// smoothing, and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import mdas_pkg::*;

  typedef logic [DEPTH_BITS-1:0] depth_t;
  typedef logic [DIST_W-1:0]     dist_t;

  typedef struct {
    depth_t        depth [WINDOW_SAMPLES];
    dist_t         hint;
    logic [MS_W-1:0] ms;
    logic          restart;
  } window_t;

  typedef struct {
    dist_t            focus;
    dist_t            visible;
    logic             used;
    logic [COUNT_W-1:0] count;
    logic             fvalid;
  } focus_res_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mdas_in_if  req ();
  mdas_out_if rsp ();

  median_depth_autofocus_smoother dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
  );

  // Predictor state and register copies.
  logic [63:0] m_near, m_far, m_limit, m_smooth;
  logic        m_held;
  focus_res_t  expected_q [$];
  int          errors;
  int          cycles;
  int          hold_cycles;
  bit          stall_en;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 1000000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [63:0] decay_keep(input int unsigned t);
    logic [63:0] k;
    k = 64'd1 << 30;
    for (int unsigned i = 0; i < t; i++) k = (k * 64'd1070678369 + (64'd1 << 29)) >> 30;
    return k;
  endfunction

  // Computes the expected result of one window and advances the held focus.
  function automatic focus_res_t predict_focus(input window_t w);
    focus_res_t  r;
    logic [63:0] kept [WINDOW_SAMPLES];
    logic [63:0] x, d, den, vis, diff, target, alpha, stp;
    int          n, j;
    bit          have, used;
    n = 0; vis = 0; have = 0; used = 0;
    if (w.restart) begin
      m_held = 1'b0;
      r.focus = m_smooth[DIST_W-1:0];
      r.visible = '0; r.used = 0; r.count = '0; r.fvalid = 0;
      return r;
    end
    for (int i = 0; i < WINDOW_SAMPLES; i++) begin
      if (w.depth[i] > 0 && w.depth[i] < m_limit) begin
        x = 64'(w.depth[i]);
        j = n;
        while (j > 0 && kept[j-1] > x) begin
          kept[j] = kept[j-1];
          j--;
        end
        kept[j] = x;
        n++;
      end
    end
    if (n >= MIN_KEPT && m_far > m_near) begin
      d = kept[n/2];
      den = m_far - ((d * (m_far - m_near)) >> DEPTH_BITS);
      vis = (m_near * m_far) / den;
      have = 1;
    end
    if (have && vis > m_near && vis < m_far) begin
      diff = (vis > w.hint) ? vis - w.hint : w.hint - vis;
      if (4 * diff < w.hint) used = 1;
    end
    target = used ? vis : 64'(w.hint);
    if (!m_held) m_smooth = target;
    else begin
      alpha = (64'd1 << 30) - decay_keep((w.ms > 250) ? 250 : w.ms);
      if (target >= m_smooth) begin
        stp = ((target - m_smooth) * alpha + (64'd1 << 29)) >> 30;
        m_smooth += stp;
      end else begin
        stp = ((m_smooth - target) * alpha + (64'd1 << 29)) >> 30;
        m_smooth -= stp;
      end
    end
    m_held = 1'b1;
    r.focus = m_smooth[DIST_W-1:0];
    r.visible = vis[DIST_W-1:0];
    r.used = used;
    r.count = n[COUNT_W-1:0];
    r.fvalid = 1;
    return r;
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Sends one window transaction and records its expected result.
  task automatic send_window(input window_t w);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.depth_0       <= w.depth[0];
    req.depth_1       <= w.depth[1];
    req.depth_2       <= w.depth[2];
    req.depth_3       <= w.depth[3];
    req.depth_4       <= w.depth[4];
    req.depth_5       <= w.depth[5];
    req.depth_6       <= w.depth[6];
    req.depth_7       <= w.depth[7];
    req.depth_8       <= w.depth[8];
    req.hint_distance <= w.hint;
    req.elapsed_ms    <= w.ms;
    req.restart       <= w.restart;
    do @(posedge clk); while (!req.ready);
    expected_q.push_back(predict_focus(w));
  endtask

  // Result receiver with random stalls and an optional long hold-off.
  initial begin
    int g;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp.ready <= 1'b0;
      end else if (stall_en && $urandom_range(0, 3) == 0) begin
        rsp.ready <= 1'b0;
        g = rand_gap() + 1;
        repeat (g) @(posedge clk);
        rsp.ready <= 1'b1;
      end else rsp.ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    focus_res_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (rsp.focus_distance !== e.focus) begin
          $error("focus_distance expected %0d actual %0d", e.focus, rsp.focus_distance);
          errors++;
        end
        if (rsp.visible_distance !== e.visible) begin
          $error("visible_distance expected %0d actual %0d", e.visible,
                 rsp.visible_distance);
          errors++;
        end
        if (rsp.used_visible !== e.used) begin
          $error("used_visible expected %0d actual %0d", e.used, rsp.used_visible);
          errors++;
        end
        if (rsp.valid_count !== e.count) begin
          $error("valid_count expected %0d actual %0d", e.count, rsp.valid_count);
          errors++;
        end
        if (rsp.focus_valid !== e.fvalid) begin
          $error("focus_valid expected %0d actual %0d", e.fvalid, rsp.focus_valid);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Writes one register while the block is idle.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_NEAR:  m_near = 64'(val);
      CFG_FAR:   m_far = 64'(val);
      default:   m_limit = 64'(val);
    endcase
  endtask

  // Random window: depths mostly in range, sometimes zero or background.
  function automatic window_t rand_window(input int restart_pct);
    window_t w;
    int base;
    base = $urandom_range(1, 24'hFFFFFF);
    for (int i = 0; i < WINDOW_SAMPLES; i++) begin
      case ($urandom_range(0, 9))
        0: w.depth[i] = '0;
        1: w.depth[i] = 24'hFFFFFF;
        2: w.depth[i] = 24'($urandom());
        default: w.depth[i] = 24'(base + $urandom_range(0, 4000) - 2000);
      endcase
    end
    w.hint = 24'($urandom());
    w.ms = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 300));
    w.restart = ($urandom_range(0, 99) < restart_pct);
    return w;
  endfunction

  // Builds a window whose hint is usually set near the distance predicted from its fifth depth.
  function automatic window_t tracking_window();
    window_t w;
    logic [63:0] d, den, vis;
    w = rand_window(0);
    if (m_far > m_near) begin
      d = 64'(w.depth[4]);
      den = m_far - ((d * (m_far - m_near)) >> DEPTH_BITS);
      vis = (m_near * m_far) / den;
      if ($urandom_range(0, 3) != 0)
        w.hint = 24'(vis + $urandom_range(0, 200) - 100);
    end
    return w;
  endfunction

  task automatic test_directed();
    window_t w;
    w = rand_window(0);
    // All samples at the field extremes: nothing kept.
    foreach (w.depth[i]) w.depth[i] = '0;
    w.hint = '0; w.ms = '0; send_window(w);
    foreach (w.depth[i]) w.depth[i] = 24'hFFFFFF;
    w.hint = 24'hFFFFFF; w.ms = 16'hFFFF; send_window(w);
    // Exactly two and exactly three kept.
    foreach (w.depth[i]) w.depth[i] = (i < 2) ? 24'h800000 : 24'h0;
    w.hint = 24'd8192; w.ms = 16'd100; send_window(w);
    foreach (w.depth[i]) w.depth[i] = (i < 3) ? 24'(24'h100000 * (i + 1)) : 24'h0;
    send_window(w);
    // Full window with a median, zero elapsed, capped elapsed.
    foreach (w.depth[i]) w.depth[i] = 24'(24'h000100 + i);
    w.ms = 16'd0; send_window(w);
    w.ms = 16'd251; send_window(w);
    w.ms = 16'd250; send_window(w);
    // Restart then a fresh first target.
    w.restart = 1'b1; send_window(w);
    w.restart = 1'b0; w.ms = 16'd1; send_window(w);
    for (int i = 0; i < 16; i++) send_window(tracking_window());
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_NEAR, 24'd1);
    write_reg(CFG_FAR, 24'hFFFFFF);
    write_reg(CFG_LIMIT, 24'hFFFFFF);
    for (int i = 0; i < 200; i++) send_window(tracking_window());
    // Far not above near.
    write_reg(CFG_FAR, 24'd1);
    for (int i = 0; i < 40; i++) send_window(rand_window(10));
    write_reg(CFG_NEAR, 24'hFFFFFF);
    write_reg(CFG_LIMIT, 24'd1);
    for (int i = 0; i < 40; i++) send_window(rand_window(10));
    write_reg(CFG_NEAR, 24'd4096);
    write_reg(CFG_FAR, 24'd409600);
    write_reg(CFG_LIMIT, 24'hFF0000);
    for (int i = 0; i < 300; i++) send_window(tracking_window());
  endtask

  task automatic test_backpressure();
    write_reg(CFG_NEAR, 24'($urandom_range(1, 20000)));
    write_reg(CFG_FAR, 24'($urandom_range(100000, 24'hFFFFFF)));
    write_reg(CFG_LIMIT, 24'($urandom_range(24'h800000, 24'hFFFFFF)));
    hold_cycles = 2000;
    for (int i = 0; i < 20; i++) send_window(tracking_window());
  endtask

  task automatic test_random();
    stall_en = 1;
    for (int i = 0; i < 1200; i++) begin
      if (i % 5 == 0) send_window(rand_window(5));
      else send_window(tracking_window());
    end
  endtask

  initial begin
    errors = 0; hold_cycles = 0; stall_en = 0;
    rst = 1'b1; cfg_we = 1'b0; cfg_index = CFG_NEAR; cfg_data = '0;
    req.valid = 1'b0; req.depth_0 = '0; req.depth_1 = '0; req.depth_2 = '0;
    req.depth_3 = '0; req.depth_4 = '0; req.depth_5 = '0; req.depth_6 = '0;
    req.depth_7 = '0; req.depth_8 = '0; req.hint_distance = '0;
    req.elapsed_ms = '0; req.restart = 1'b0;
    m_near = 64'(NEAR_RESET); m_far = 64'(FAR_RESET); m_limit = 64'(LIMIT_RESET);
    m_smooth = 0; m_held = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
